// ===== rtl/core/bmhq_pkg.sv =====
// shared types and constants for the binary min-heap queue
`default_nettype none

package bmhq_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 64;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_PEEK = 2'd2,
        FUNC_NOP  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/binary_min_heap_queue.sv =====
// top level of the binary min-heap priority queue with its output register
`default_nettype none

// A fixed-capacity binary min-heap on unsigned keys: each request enqueues a key,
// dequeues the minimum, peeks at it or does nothing, and returns one result with
// a status and the entry count. Requests are handled one at a time and every heap
// level costs one memory round trip through a check state and a compare state. A
// new key climbs up towards the root and the entry moved to the root on a dequeue
// sinks down, each by at most ceil(log2(CAPACITY)) levels. The result waits in
// an output register, so a new request is accepted while the previous result is
// unread; a second finished result holds the sequencer until the output register
// drains.
module binary_min_heap_queue #(
    parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = bmhq_pkg::DEF_KEY_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [bmhq_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [bmhq_pkg::KEY_W-1:0]    i_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [bmhq_pkg::KEY_W-1:0]    o_result_key,
    output logic      [bmhq_pkg::STATUS_W-1:0] o_status,
    output logic      [bmhq_pkg::COUNT_W-1:0]  o_count
);

    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                 w_idle;
    logic                 w_res_valid;
    logic                 w_res_take;
    t_result              w_res;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [KEY_WIDTH-1:0] w_wr_data;
    logic [AW-1:0]        w_rd_addr_a;
    logic [AW-1:0]        w_rd_addr_b;
    logic [KEY_WIDTH-1:0] w_rd_data_a;
    logic [KEY_WIDTH-1:0] w_rd_data_b;

    logic                 r_out_valid;
    t_result              r_out;

    assign o_in_ready = w_idle;
    assign w_res_take = w_res_valid && (!r_out_valid || i_out_ready);

    bmhq_seq #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && w_idle),
        .i_func      (t_func'(i_func)),
        .i_key       (i_key[KEY_WIDTH-1:0]),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .i_rd_data_a (w_rd_data_a),
        .i_rd_data_b (w_rd_data_b)
    );

    bmhq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_result_key = r_out.key;
    assign o_status     = r_out.status;
    assign o_count      = r_out.count;

endmodule

`default_nettype wire

// ===== rtl/core/bmhq_store.sv =====
// heap storage: one write port, two registered read ports
`default_nettype none

module bmhq_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bmhq_seq.sv =====
// heap sequencer: enqueue sift-up, dequeue sift-down, peek, entry count
`default_nettype none

module bmhq_seq #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire bmhq_pkg::t_func              i_func,
    input  wire logic [KEY_WIDTH-1:0]         i_key,
    output logic                              o_idle,
    output logic                              o_res_valid,
    input  wire logic                         i_res_take,
    output bmhq_pkg::t_result                 o_res,
    output logic                              o_wr_en,
    output logic      [$clog2(CAPACITY)-1:0]  o_wr_addr,
    output logic      [KEY_WIDTH-1:0]         o_wr_data,
    output logic      [$clog2(CAPACITY)-1:0]  o_rd_addr_a,
    output logic      [$clog2(CAPACITY)-1:0]  o_rd_addr_b,
    input  wire logic [KEY_WIDTH-1:0]         i_rd_data_a,
    input  wire logic [KEY_WIDTH-1:0]         i_rd_data_b
);

    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(2 * CAPACITY + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DQ_LOAD,
        S_PK_LOAD,
        S_DN_CHK,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [PW-1:0]        r_pos;
    logic [KEY_WIDTH-1:0] r_val;
    logic [KEY_WIDTH-1:0] r_res_key;
    t_status              r_status;

    logic [PW-1:0]        w_left;
    logic [PW-1:0]        w_right;
    logic                 w_has_right;
    logic                 w_pick_right;
    logic [KEY_WIDTH-1:0] w_child;

    assign w_left       = PW'({r_pos, 1'b0});
    assign w_right      = w_left + 1'b1;
    assign w_has_right  = (w_right <= PW'(r_count));
    assign w_pick_right = w_has_right && (i_rd_data_b < i_rd_data_a);
    assign w_child      = w_pick_right ? i_rd_data_b : i_rd_data_a;

    // memory port control
    always_comb begin
        o_wr_en     = 1'b0;
        o_wr_addr   = AW'(r_pos - 1'b1);
        o_wr_data   = r_val;
        o_rd_addr_a = '0;
        o_rd_addr_b = AW'(r_count - 1'b1);
        unique case (r_state)
            S_UP_CHK: begin
                o_rd_addr_a = AW'((r_pos >> 1) - 1'b1);
                o_wr_en     = (r_pos == PW'(1));
            end
            S_UP_CMP: begin
                o_wr_en = 1'b1;
                if (r_val < i_rd_data_a) begin
                    o_wr_data = i_rd_data_a;
                end
            end
            S_DN_CHK: begin
                o_rd_addr_a = AW'(w_left - 1'b1);
                o_rd_addr_b = AW'(w_left);
                o_wr_en     = (w_left > PW'(r_count));
            end
            S_DN_CMP: begin
                o_wr_en = 1'b1;
                if (r_val > w_child) begin
                    o_wr_data = w_child;
                end
            end
            S_IDLE, S_DQ_LOAD, S_PK_LOAD, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_res_key <= '0;
                        unique case (i_func)
                            FUNC_ENQ: begin
                                if (r_count == CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_count  <= r_count + 1'b1;
                                    r_pos    <= PW'(r_count) + 1'b1;
                                    r_val    <= i_key;
                                    r_state  <= S_UP_CHK;
                                end
                            end
                            FUNC_DEQ, FUNC_PEEK: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else if (i_func == FUNC_DEQ) begin
                                    r_status <= ST_OK;
                                    r_state  <= S_DQ_LOAD;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_PK_LOAD;
                                end
                            end
                            FUNC_NOP: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_UP_CHK: begin
                    r_state <= (r_pos == PW'(1)) ? S_DONE : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (r_val < i_rd_data_a) begin
                        r_pos   <= r_pos >> 1;
                        r_state <= S_UP_CHK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DQ_LOAD: begin
                    r_res_key <= i_rd_data_a;
                    r_val     <= i_rd_data_b;
                    r_count   <= r_count - 1'b1;
                    r_pos     <= PW'(1);
                    r_state   <= (r_count == CW'(1)) ? S_DONE : S_DN_CHK;
                end
                S_PK_LOAD: begin
                    r_res_key <= i_rd_data_a;
                    r_state   <= S_DONE;
                end
                S_DN_CHK: begin
                    r_state <= (w_left > PW'(r_count)) ? S_DONE : S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (r_val > w_child) begin
                        r_pos   <= w_pick_right ? w_right : w_left;
                        r_state <= S_DN_CHK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.key    = KEY_W'(r_res_key);
    assign o_res.status = r_status;
    assign o_res.count  = COUNT_W'(r_count);

endmodule

`default_nettype wire
